// ----- hdl/affine_point_map_decimator_defines.svh -----
// Assertion helpers for the affine point mapper.
`ifndef AFFINE_POINT_MAP_DECIMATOR_DEFINES_SVH
`define AFFINE_POINT_MAP_DECIMATOR_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define APMD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("apmd check failed");

// Next-cycle implication, off while reset is asserted.
`define APMD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("apmd check failed");

// Next-cycle implication that also watches reset itself.
`define APMD_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("apmd reset check failed");

`endif

// ----- hdl/apmd_pkg.sv -----
package apmd_pkg;

  localparam int unsigned PIX_W   = 12;
  localparam int unsigned COEF_W  = 32;
  localparam int unsigned SPACE_W = 31;
  localparam int unsigned PROD_W  = COEF_W + PIX_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 2;

  localparam int unsigned FIFO_DEPTH_DEF = 4;

  localparam logic [COEF_W-1:0]  COEF_XX_RST  = 32'h0001_0000;
  localparam logic [COEF_W-1:0]  COEF_XY_RST  = 32'h0000_0000;
  localparam logic [COEF_W-1:0]  OFFSET_X_RST = 32'h0000_0000;
  localparam logic [COEF_W-1:0]  COEF_YX_RST  = 32'h0000_0000;
  localparam logic [COEF_W-1:0]  COEF_YY_RST  = 32'h0001_0000;
  localparam logic [COEF_W-1:0]  OFFSET_Y_RST = 32'h0000_0000;
  localparam logic [SPACE_W-1:0] SPACING_RST  = 31'h0000_8000;

  localparam logic [2:0] REG_COEF_XX     = 3'd0;
  localparam logic [2:0] REG_COEF_XY     = 3'd1;
  localparam logic [2:0] REG_OFFSET_X    = 3'd2;
  localparam logic [2:0] REG_COEF_YX     = 3'd3;
  localparam logic [2:0] REG_COEF_YY     = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd5;
  localparam logic [2:0] REG_MIN_SPACING = 3'd6;

  typedef struct packed {
    logic [COEF_W-1:0] coef_xx;
    logic [COEF_W-1:0] coef_xy;
    logic [COEF_W-1:0] offset_x;
    logic [COEF_W-1:0] coef_yx;
    logic [COEF_W-1:0] coef_yy;
    logic [COEF_W-1:0] offset_y;
  } apmd_coef_t;

  typedef struct packed {
    logic [COEF_W-1:0] real_x;
    logic [COEF_W-1:0] real_y;
    logic              saturated;
    logic              path_start;
  } apmd_point_t;

endpackage

// ----- hdl/apmd_front.sv -----
module apmd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [11:0]         pixel_x,
  input  logic [11:0]         pixel_y,
  input  logic                path_start,
  input  apmd_pkg::apmd_coef_t coef,
  output logic                wr_en,
  output apmd_pkg::apmd_point_t wr_data,
  output logic [1:0]          fill
);
  import apmd_pkg::*;

  logic                     v1_r, v2_r;
  logic                     start1_r, start2_r;
  logic signed [PROD_W-1:0] p_xx_r, p_xy_r, p_yx_r, p_yy_r;
  logic signed [SUM_W-1:0]  sum_x_r, sum_y_r;
  logic signed [PIX_W:0]    px_s, py_s;
  logic                     clip_x, clip_y;

  assign px_s = $signed({1'b0, pixel_x});
  assign py_s = $signed({1'b0, pixel_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
    end
  end

  // Stage 1: four products. Stage 2: two sums.
  always_ff @(posedge clk) begin
    if (acc) begin
      p_xx_r   <= $signed(coef.coef_xx) * px_s;
      p_xy_r   <= $signed(coef.coef_xy) * py_s;
      p_yx_r   <= $signed(coef.coef_yx) * px_s;
      p_yy_r   <= $signed(coef.coef_yy) * py_s;
      start1_r <= path_start;
    end
    if (v1_r) begin
      sum_x_r  <= SUM_W'(p_xx_r) + SUM_W'(p_xy_r) + SUM_W'($signed(coef.offset_x));
      sum_y_r  <= SUM_W'(p_yx_r) + SUM_W'(p_yy_r) + SUM_W'($signed(coef.offset_y));
      start2_r <= start1_r;
    end
  end

  // In range when every bit from 31 up matches the sign.
  assign clip_x = !((&sum_x_r[SUM_W-1:COEF_W-1]) || !(|sum_x_r[SUM_W-1:COEF_W-1]));
  assign clip_y = !((&sum_y_r[SUM_W-1:COEF_W-1]) || !(|sum_y_r[SUM_W-1:COEF_W-1]));

  always_comb begin
    wr_data.real_x     = sum_x_r[COEF_W-1:0];
    wr_data.real_y     = sum_y_r[COEF_W-1:0];
    if (clip_x) begin
      wr_data.real_x = sum_x_r[SUM_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                        : {1'b0, {(COEF_W-1){1'b1}}};
    end
    if (clip_y) begin
      wr_data.real_y = sum_y_r[SUM_W-1] ? {1'b1, {(COEF_W-1){1'b0}}}
                                        : {1'b0, {(COEF_W-1){1'b1}}};
    end
    wr_data.saturated  = clip_x || clip_y;
    wr_data.path_start = start2_r;
  end

  assign wr_en = v2_r;
  assign fill  = {1'b0, v1_r} + {1'b0, v2_r};

endmodule

// ----- hdl/apmd_fifo.sv -----
module apmd_fifo #(
  parameter int unsigned DEPTH = apmd_pkg::FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  apmd_pkg::apmd_point_t         wr_data,
  input  logic                          rd_en,
  output apmd_pkg::apmd_point_t         rd_data,
  output logic                          rd_valid,
  output logic [$clog2(DEPTH+1)-1:0]    count
);
  import apmd_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  apmd_point_t   mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr_en) begin
      wp_nxt = (wp_r == LAST) ? '0 : wp_r + 1'b1;
    end
    if (rd_en) begin
      rp_nxt = (rp_r == LAST) ? '0 : rp_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  assign rd_data  = mem_r[rp_r];
  assign rd_valid = (cnt_r != '0);
  assign count    = cnt_r;

endmodule

// ----- hdl/apmd_back.sv -----
module apmd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  apmd_pkg::apmd_point_t head,
  output logic                  pop,
  input  logic [30:0]           min_spacing,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_real_x,
  output logic [31:0]           out_real_y,
  output logic                  out_kept,
  output logic                  out_saturated
);
  import apmd_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  logic [COEF_W-1:0] last_x_r;
  logic              have_r;
  logic [COEF_W:0]   d_fwd, d_rev, mag;
  logic              keep;

  // Distance to the last kept x, both ways at once, then pick the positive one.
  assign d_fwd = {head.real_x[COEF_W-1], head.real_x} - {last_x_r[COEF_W-1], last_x_r};
  assign d_rev = {last_x_r[COEF_W-1], last_x_r} - {head.real_x[COEF_W-1], head.real_x};
  assign mag   = d_fwd[COEF_W] ? d_rev : d_fwd;
  assign keep  = head.path_start || !have_r || (mag >= {2'b00, min_spacing});

  assign pop = head_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      have_r      <= 1'b0;
      last_x_r    <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop && keep) begin
        have_r   <= 1'b1;
        last_x_r <= head.real_x;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_real_x    <= head.real_x;
      out_real_y    <= head.real_y;
      out_kept      <= keep;
      out_saturated <= head.saturated;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- hdl/affine_point_map_decimator.sv -----
// Channel   Dir  Handshake            Beat contents
// in_*      in   in_valid/in_stall    pixel_x, pixel_y, path_start
// out_*     out  out_valid/out_stall  real_x, real_y, kept, saturated
// APB       in   psel/penable/pready  seven registers at byte address 4*index
//
// One beat per cycle sustained while out_stall is low; each beat passes the product
// stage, sum stage, queue and output register in that order.
// in_stall rises once the queue plus the two mapping stages hold FIFO_DEPTH beats,
// so a long out_stall fills the queue and then holds the input.
// Synchronous active-low reset restores register defaults and empties the pipeline;
// the first point after reset is always kept.
module affine_point_map_decimator #(
  parameter int unsigned FIFO_DEPTH = apmd_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_pixel_x,
  input  logic [11:0] in_pixel_y,
  input  logic        in_path_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_real_x,
  output logic [31:0] out_real_y,
  output logic        out_kept,
  output logic        out_saturated,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import apmd_pkg::*;

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  apmd_coef_t         coef_r;
  logic [SPACE_W-1:0] spacing_r;
  logic [2:0]         reg_idx;
  logic               cfg_wr;
  logic               in_acc;
  logic               wr_en, pop, head_valid;
  apmd_point_t        wr_data, head;
  logic [1:0]         front_fill;
  logic [CW-1:0]      fifo_cnt;
  logic [CW:0]        occupancy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.coef_xx  <= COEF_XX_RST;
      coef_r.coef_xy  <= COEF_XY_RST;
      coef_r.offset_x <= OFFSET_X_RST;
      coef_r.coef_yx  <= COEF_YX_RST;
      coef_r.coef_yy  <= COEF_YY_RST;
      coef_r.offset_y <= OFFSET_Y_RST;
      spacing_r       <= SPACING_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COEF_XX:     coef_r.coef_xx  <= pwdata;
        REG_COEF_XY:     coef_r.coef_xy  <= pwdata;
        REG_OFFSET_X:    coef_r.offset_x <= pwdata;
        REG_COEF_YX:     coef_r.coef_yx  <= pwdata;
        REG_COEF_YY:     coef_r.coef_yy  <= pwdata;
        REG_OFFSET_Y:    coef_r.offset_y <= pwdata;
        REG_MIN_SPACING: spacing_r       <= pwdata[SPACE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COEF_XX:     prdata = coef_r.coef_xx;
      REG_COEF_XY:     prdata = coef_r.coef_xy;
      REG_OFFSET_X:    prdata = coef_r.offset_x;
      REG_COEF_YX:     prdata = coef_r.coef_yx;
      REG_COEF_YY:     prdata = coef_r.coef_yy;
      REG_OFFSET_Y:    prdata = coef_r.offset_y;
      REG_MIN_SPACING: prdata = {1'b0, spacing_r};
      default:         prdata = '0;
    endcase
  end

  // Hold input while every queue slot is spoken for.
  assign occupancy = {1'b0, fifo_cnt} + (CW + 1)'(front_fill);
  assign in_stall  = (occupancy >= (CW + 1)'(FIFO_DEPTH));
  assign in_acc    = in_valid && !in_stall;

  apmd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .pixel_x    (in_pixel_x),
    .pixel_y    (in_pixel_y),
    .path_start (in_path_start),
    .coef       (coef_r),
    .wr_en      (wr_en),
    .wr_data    (wr_data),
    .fill       (front_fill)
  );

  apmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .rd_en    (pop),
    .rd_data  (head),
    .rd_valid (head_valid),
    .count    (fifo_cnt)
  );

  apmd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .min_spacing   (spacing_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_real_x    (out_real_x),
    .out_real_y    (out_real_y),
    .out_kept      (out_kept),
    .out_saturated (out_saturated)
  );

endmodule

// ----- hdl/apmd_checker.sv -----
`include "affine_point_map_decimator_defines.svh"

module apmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_real_x,
  input logic [31:0] out_real_y,
  input logic        out_kept,
  input logic        out_saturated
);

  logic [65:0] out_beat;
  logic        on_rail;

  assign out_beat = {out_real_x, out_real_y, out_kept, out_saturated};
  assign on_rail  = (out_real_x == 32'h7fff_ffff) || (out_real_x == 32'h8000_0000) ||
                    (out_real_y == 32'h7fff_ffff) || (out_real_y == 32'h8000_0000);

  // A clipped result must sit on a rail in at least one axis.
  `APMD_ASSERT_NOW(a_sat_on_rail, out_valid && out_saturated, on_rail)

  `APMD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_beat))

  `APMD_ASSERT_RST(a_rst_empty, !rst_n, !out_valid)

endmodule

bind affine_point_map_decimator apmd_checker u_apmd_checker (.*);

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import apmd_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [31:0] real_x;
    logic [31:0] real_y;
    logic        kept;
    logic        saturated;
  } mapped_t;

  typedef enum logic {ROW_POINT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [11:0] px;
    logic [11:0] py;
    logic        ps;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    bit          typed;
    mapped_t     want;
  } step_t;

  // Directed rows: typed results only where they follow by inspection.
  localparam step_t DIRECTED [0:27] = '{
    // first point after reset is kept without path_start, then a repeat is dropped
    '{ROW_POINT, 12'd0, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h0, 32'h0, 1'b1, 1'b0}},
    '{ROW_POINT, 12'd0, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h0, 32'h0, 1'b0, 1'b0}},
    '{ROW_POINT, 12'd4095, 12'd4095, 1'b0, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h0FFF_0000, 32'h0FFF_0000, 1'b1, 1'b0}},
    '{ROW_POINT, 12'd4095, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h0FFF_0000, 32'h0, 1'b0, 1'b0}},
    '{ROW_POINT, 12'd4094, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h0FFE_0000, 32'h0, 1'b1, 1'b0}},
    '{ROW_POINT, 12'd4094, 12'd5, 1'b1, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h0FFE_0000, 32'h0005_0000, 1'b1, 1'b0}},
    '{ROW_POINT, 12'hAAA, 12'h555, 1'b0, REG_COEF_XX, 32'h0, 1'b0, '0},
    '{ROW_POINT, 12'h555, 12'hAAA, 1'b1, REG_COEF_XX, 32'h0, 1'b0, '0},
    // coefficient extremes, zero spacing
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_COEF_XX, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_COEF_XY, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_OFFSET_X, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_COEF_YX, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_COEF_YY, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_OFFSET_Y, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_MIN_SPACING, 32'h0, 1'b0, '0},
    '{ROW_POINT, 12'd0, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0}},
    '{ROW_POINT, 12'd1, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1}},
    '{ROW_POINT, 12'd4095, 12'd4095, 1'b1, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1}},
    '{ROW_POINT, 12'd0, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0}},
    // write past the last register must change nothing
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_UNUSED, 32'h1234_5678, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_COEF_XX, 32'h8000_0000, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_COEF_XY, 32'h0, 1'b0, '0},
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_OFFSET_X, 32'h7FFF_FFFF, 1'b0, '0},
    // top bit of spacing is dropped, leaving the largest spacing
    '{ROW_CFG, 12'd0, 12'd0, 1'b0, REG_MIN_SPACING, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_POINT, 12'd0, 12'd0, 1'b1, REG_COEF_XX, 32'h0, 1'b0, '0},
    '{ROW_POINT, 12'd1, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b0, '0},
    '{ROW_POINT, 12'd2, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b0, '0},
    '{ROW_POINT, 12'd1, 12'd0, 1'b0, REG_COEF_XX, 32'h0, 1'b0, '0}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [11:0] in_pixel_x;
  logic [11:0] in_pixel_y;
  logic        in_path_start;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_real_x;
  logic [31:0] out_real_y;
  logic        out_kept;
  logic        out_saturated;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] cfg_mdl [0:6];
  logic [31:0] last_kept_x;
  bit          have_kept;
  mapped_t     pending_pts [$];
  int          fails;
  bit          idle_en;
  bit          hold_out;

  affine_point_map_decimator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .in_path_start (in_path_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_real_x    (out_real_x),
    .out_real_y    (out_real_y),
    .out_kept      (out_kept),
    .out_saturated (out_saturated),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  function automatic logic [31:0] affine_axis(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] c, input logic [11:0] px,
                                              input logic [11:0] py, output logic clip);
    longint s;
    s = longint'($signed(a)) * longint'(px) + longint'($signed(b)) * longint'(py)
        + longint'($signed(c));
    clip = 1'b0;
    if (s > 64'sd2147483647) begin
      clip = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (s < -64'sd2147483648) begin
      clip = 1'b1;
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  // Map one point and advance the decimation state.
  function automatic mapped_t predict_point(input logic [11:0] px, input logic [11:0] py,
                                            input logic start);
    mapped_t r;
    logic    cx;
    logic    cy;
    longint  x_gap;
    r.real_x = affine_axis(cfg_mdl[REG_COEF_XX], cfg_mdl[REG_COEF_XY],
                           cfg_mdl[REG_OFFSET_X], px, py, cx);
    r.real_y = affine_axis(cfg_mdl[REG_COEF_YX], cfg_mdl[REG_COEF_YY],
                           cfg_mdl[REG_OFFSET_Y], px, py, cy);
    r.saturated = cx | cy;
    if (start || !have_kept) begin
      r.kept = 1'b1;
    end else begin
      x_gap = longint'($signed(r.real_x)) - longint'($signed(last_kept_x));
      if (x_gap < 0) x_gap = -x_gap;
      r.kept = (x_gap >= longint'(cfg_mdl[REG_MIN_SPACING]));
    end
    if (r.kept) begin
      last_kept_x = r.real_x;
      have_kept = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_reg(input logic [2:0] idx);
    if (idx == REG_MIN_SPACING) begin
      case ($urandom_range(0, 3))
        0: return 32'h0;
        1: return $urandom_range(0, 1 << 20);
        2: return 32'hFFFF_FFFF;
        default: return $urandom();
      endcase
    end
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      2: return 32'h0;
      default: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
    endcase
  endfunction

  // Write a register, then read it back.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx != REG_UNUSED)
      cfg_mdl[idx] = (idx == REG_MIN_SPACING) ? {1'b0, val[30:0]} : val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx != REG_UNUSED && prdata !== cfg_mdl[idx]) begin
      $error("prdata: expected %h, got %h", cfg_mdl[idx], prdata);
      fails++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_point(input logic [11:0] px, input logic [11:0] py, input logic ps,
                            input bit typed, input mapped_t want);
    mapped_t r;
    int      gap;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    in_path_start <= ps;
    do @(posedge clk); while (in_stall);
    r = predict_point(px, py, ps);
    pending_pts = {pending_pts, (typed ? want : r)};
  endtask

  // Drop valid and let every outstanding result come back.
  task automatic drain_points();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  initial begin : out_side
    int n;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 19);
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    mapped_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pts.size() == 0) begin
        $error("unexpected result beat: real_x %h real_y %h", out_real_x, out_real_y);
        fails++;
      end else begin
        want = pending_pts.pop_front();
        if (out_real_x !== want.real_x) begin
          $error("real_x: expected %h, got %h", want.real_x, out_real_x);
          fails++;
        end
        if (out_real_y !== want.real_y) begin
          $error("real_y: expected %h, got %h", want.real_y, out_real_y);
          fails++;
        end
        if (out_kept !== want.kept) begin
          $error("kept: expected %b, got %b", want.kept, out_kept);
          fails++;
        end
        if (out_saturated !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, out_saturated);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    int   cur_x;
    int   cur_y;
    logic starts_path;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_path_start = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fails = 0;
    idle_en = 1'b1;
    hold_out = 1'b0;
    cur_x = 0;
    cur_y = 0;
    cfg_mdl[REG_COEF_XX] = COEF_XX_RST;
    cfg_mdl[REG_COEF_XY] = COEF_XY_RST;
    cfg_mdl[REG_OFFSET_X] = OFFSET_X_RST;
    cfg_mdl[REG_COEF_YX] = COEF_YX_RST;
    cfg_mdl[REG_COEF_YY] = COEF_YY_RST;
    cfg_mdl[REG_OFFSET_Y] = OFFSET_Y_RST;
    cfg_mdl[REG_MIN_SPACING] = {1'b0, SPACING_RST};
    last_kept_x = '0;
    have_kept = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        drain_points();
        cfg_write(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        send_point(DIRECTED[i].px, DIRECTED[i].py, DIRECTED[i].ps,
                   DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Random paths: mostly short walks so spacing decides, with jumps and restarts.
    for (int ph = 0; ph < 6; ph++) begin
      idle_en = (ph < 5);
      drain_points();
      for (int k = REG_COEF_XX; k <= REG_MIN_SPACING; k++)
        cfg_write(3'(k), rand_reg(3'(k)));
      for (int n = 0; n < 180; n++) begin
        if (ph == 1 && n == 60) hold_out = 1'b1;
        starts_path = ($urandom_range(0, 15) == 0);
        if (starts_path || $urandom_range(0, 19) == 0) begin
          cur_x = $urandom_range(0, 4095);
          cur_y = $urandom_range(0, 4095);
        end else begin
          cur_x = cur_x + int'($urandom_range(0, 6)) - 3;
          cur_y = cur_y + int'($urandom_range(0, 6)) - 3;
          if (cur_x < 0) cur_x = 0;
          if (cur_x > 4095) cur_x = 4095;
          if (cur_y < 0) cur_y = 0;
          if (cur_y > 4095) cur_y = 4095;
        end
        send_point(cur_x[11:0], cur_y[11:0], starts_path, 1'b0, '0);
      end
    end

    drain_points();
    if (fails == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
